FILE: hw/rtl/evps_pkg.sv
// Shared types, register indexes and helpers of the emitter volume point sampler.
`default_nettype none
package evps_pkg;

    typedef enum logic [1:0] {
        SHAPE_BOX = 2'd0,
        SHAPE_CYL = 2'd1,
        SHAPE_ELL = 2'd2
    } shape_t;

    typedef enum logic [2:0] {
        REG_SHAPE_MODE = 3'd0,
        REG_CENTER     = 3'd1,
        REG_AXIS_UP    = 3'd2,
        REG_AXIS_DIR   = 3'd3,
        REG_AXIS_SIDE  = 3'd4
    } reg_index_t;

    localparam int COORD_W = 20;
    localparam int REG_W   = 60;

    localparam logic [REG_W-1:0] CENTER_RST    = 60'd0;
    localparam logic [REG_W-1:0] AXIS_UP_RST   = 60'd800;
    localparam logic [REG_W-1:0] AXIS_DIR_RST  = 60'd800 << 20;
    localparam logic [REG_W-1:0] AXIS_SIDE_RST = 60'd800 << 40;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    function automatic logic signed [COORD_W-1:0] coord(input logic [REG_W-1:0] packed_v,
                                                       input logic [1:0] k);
        logic [COORD_W-1:0] r;
        begin
            r = 20'(packed_v >> (COORD_W * int'(k)));
            return $signed(r);
        end
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/evps_in_if.sv
// Input channel carrying three Q1.15 random values per beat.
`default_nettype none
interface evps_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rand_a;
    logic signed [15:0] rand_b;
    logic signed [15:0] rand_c;

    modport source (output valid, output rand_a, output rand_b, output rand_c, input ready);
    modport sink   (input valid, input rand_a, input rand_b, input rand_c, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/evps_out_if.sv
// Output channel carrying one sampled position per beat.
`default_nettype none
interface evps_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
    logic               saturated;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output saturated, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input saturated, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/emitter_volume_point_sampler_core.sv
// Top level of the emitter volume point sampler: a 39-stage point pipeline.
//
// Channel    | Dir | Contents
// samples    | in  | rand_a, rand_b, rand_c (Q1.15)
// positions  | out | pos_x, pos_y, pos_z (20-bit, 4 fraction bits), saturated
// wr_*       | in  | register write: wr_en, wr_index, wr_data
//
// One beat is accepted per cycle unless a stall at the positions output holds the pipeline.
// The pipeline depth is set by the 16-step square root and the 16-step divider, one bit per stage.
// Each stage holds only while the one after it is full and held, so bubbles are squeezed out.
// Reset clears the valid bits and loads the register reset values.
`default_nettype none
module emitter_volume_point_sampler_core
    import evps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    evps_in_if.sink          samples,
    evps_out_if.source       positions,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [59:0] wr_data
);

    localparam int NSTAGE   = 39;
    localparam int SQ_FIRST = 3;
    localparam int DV_FIRST = 19;
    localparam int SEL_ST   = 35;
    localparam int MUL_ST   = 36;
    localparam int ADD_ST   = 37;
    localparam int SAT_ST   = 38;

    typedef struct packed {
        logic [2:0][15:0] v;
        logic [2:0][30:0] sq;
        logic [31:0]      s;
        logic [2:0]       scl;
        logic [15:0]      root;
        logic [17:0]      srem;
        logic [2:0][16:0] drem;
        logic [2:0][15:0] q;
        logic [8:0][35:0] prod;
        logic [2:0][37:0] acc;
        logic [2:0][19:0] pos;
        logic             sat;
    } stage_t;

    logic [1:0]  shape_reg;
    logic [59:0] center_reg;
    logic [2:0][59:0] axis_reg;

    stage_t      pipe_reg  [NSTAGE];
    stage_t      pipe_next [NSTAGE];
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg   <= SHAPE_BOX;
            center_reg  <= CENTER_RST;
            axis_reg[0] <= AXIS_UP_RST;
            axis_reg[1] <= AXIS_DIR_RST;
            axis_reg[2] <= AXIS_SIDE_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SHAPE_MODE: shape_reg   <= wr_data[1:0];
                REG_CENTER:     center_reg  <= wr_data;
                REG_AXIS_UP:    axis_reg[0] <= wr_data;
                REG_AXIS_DIR:   axis_reg[1] <= wr_data;
                REG_AXIS_SIDE:  axis_reg[2] <= wr_data;
                default:        ;
            endcase
        end
    end

    assign en[NSTAGE-1] = !valid_reg[NSTAGE-1] || positions.ready;

    genvar k;
    generate
        for (k = 0; k < NSTAGE - 1; k++)
        begin : g_en
            assign en[k] = !valid_reg[k] || en[k+1];
        end

        for (k = 0; k < NSTAGE; k++)
        begin : g_stage
            if (k == 0)
            begin : g_in
                always_comb
                begin
                    pipe_next[k]      = '0;
                    pipe_next[k].v[0] = samples.rand_a;
                    pipe_next[k].v[1] = samples.rand_b;
                    pipe_next[k].v[2] = samples.rand_c;
                end
            end
            else if (k == 1)
            begin : g_sq
                always_comb
                begin
                    pipe_next[k] = pipe_reg[k-1];
                    for (int l = 0; l < 3; l++)
                    begin
                        pipe_next[k].sq[l] = 31'($signed(pipe_reg[k-1].v[l])
                                                 * $signed(pipe_reg[k-1].v[l]));
                    end
                end
            end
            else if (k == 2)
            begin : g_sum
                logic [31:0] sum;
                always_comb
                begin
                    pipe_next[k] = pipe_reg[k-1];
                    sum = 32'(pipe_reg[k-1].sq[0]) + 32'(pipe_reg[k-1].sq[2]);
                    if (shape_reg == SHAPE_ELL)
                    begin
                        sum = sum + 32'(pipe_reg[k-1].sq[1]);
                    end
                    pipe_next[k].s    = sum;
                    pipe_next[k].root = '0;
                    pipe_next[k].srem = '0;
                    if (sum > ONE_Q30 && shape_reg == SHAPE_CYL)
                    begin
                        pipe_next[k].scl = 3'b101;
                    end
                    else if (sum > ONE_Q30 && shape_reg == SHAPE_ELL)
                    begin
                        pipe_next[k].scl = 3'b111;
                    end
                    else
                    begin
                        pipe_next[k].scl = 3'b000;
                    end
                end
            end
            else if (k < DV_FIRST)
            begin : g_sqrt
                localparam int BI = 2 * (15 - (k - SQ_FIRST));
                logic [17:0] rem_t;
                logic [17:0] trial;
                always_comb
                begin
                    pipe_next[k] = pipe_reg[k-1];
                    rem_t = {pipe_reg[k-1].srem[15:0], pipe_reg[k-1].s[BI+1:BI]};
                    trial = {pipe_reg[k-1].root, 2'b01};
                    if (rem_t >= trial)
                    begin
                        pipe_next[k].srem = rem_t - trial;
                        pipe_next[k].root = {pipe_reg[k-1].root[14:0], 1'b1};
                    end
                    else
                    begin
                        pipe_next[k].srem = rem_t;
                        pipe_next[k].root = {pipe_reg[k-1].root[14:0], 1'b0};
                    end
                end
            end
            else if (k < SEL_ST)
            begin : g_div
                localparam int J = k - DV_FIRST;
                logic [15:0] mag;
                logic [16:0] r_in;
                logic [16:0] rem_t;
                always_comb
                begin
                    pipe_next[k] = pipe_reg[k-1];
                    for (int l = 0; l < 3; l++)
                    begin
                        mag = pipe_reg[k-1].v[l][15] ? 16'(16'd0 - pipe_reg[k-1].v[l])
                                                     : pipe_reg[k-1].v[l];
                        if (J == 0)
                        begin
                            r_in  = {2'b00, mag[15:1]};
                            rem_t = {r_in[15:0], mag[0]};
                        end
                        else
                        begin
                            r_in  = pipe_reg[k-1].drem[l];
                            rem_t = {r_in[15:0], 1'b0};
                        end
                        if (rem_t >= {1'b0, pipe_reg[k-1].root})
                        begin
                            pipe_next[k].drem[l] = rem_t - {1'b0, pipe_reg[k-1].root};
                            pipe_next[k].q[l]    = {pipe_reg[k-1].q[l][14:0], 1'b1};
                        end
                        else
                        begin
                            pipe_next[k].drem[l] = rem_t;
                            pipe_next[k].q[l]    = {pipe_reg[k-1].q[l][14:0], 1'b0};
                        end
                    end
                end
            end
            else if (k == SEL_ST)
            begin : g_sel
                always_comb
                begin
                    pipe_next[k] = pipe_reg[k-1];
                    for (int l = 0; l < 3; l++)
                    begin
                        if (pipe_reg[k-1].scl[l])
                        begin
                            pipe_next[k].v[l] = pipe_reg[k-1].v[l][15]
                                              ? 16'(16'd0 - pipe_reg[k-1].q[l])
                                              : pipe_reg[k-1].q[l];
                        end
                    end
                end
            end
            else if (k == MUL_ST)
            begin : g_mul
                logic [19:0] cv;
                always_comb
                begin
                    pipe_next[k] = pipe_reg[k-1];
                    for (int c = 0; c < 3; c++)
                    begin
                        for (int l = 0; l < 3; l++)
                        begin
                            cv = coord(axis_reg[l], 2'(c));
                            pipe_next[k].prod[3*c+l] =
                                $signed({{20{pipe_reg[k-1].v[l][15]}}, pipe_reg[k-1].v[l]})
                                * $signed({{16{cv[19]}}, cv});
                        end
                    end
                end
            end
            else if (k == ADD_ST)
            begin : g_add
                always_comb
                begin
                    pipe_next[k] = pipe_reg[k-1];
                    for (int c = 0; c < 3; c++)
                    begin
                        pipe_next[k].acc[c] =
                            38'($signed(pipe_reg[k-1].prod[3*c]))
                          + 38'($signed(pipe_reg[k-1].prod[3*c+1]))
                          + 38'($signed(pipe_reg[k-1].prod[3*c+2]));
                    end
                end
            end
            else
            begin : g_sat
                logic signed [37:0] biased;
                logic signed [24:0] p;
                logic [19:0]        cc;
                always_comb
                begin
                    pipe_next[k]     = pipe_reg[k-1];
                    pipe_next[k].sat = 1'b0;
                    for (int c = 0; c < 3; c++)
                    begin
                        biased = $signed(pipe_reg[k-1].acc[c]) + 38'sd16384;
                        cc     = coord(center_reg, 2'(c));
                        p      = $signed({{5{cc[19]}}, cc}) + 25'(biased >>> 15);
                        if (p > 25'sd524287)
                        begin
                            pipe_next[k].pos[c] = 20'h7FFFF;
                            pipe_next[k].sat    = 1'b1;
                        end
                        else if (p < -25'sd524288)
                        begin
                            pipe_next[k].pos[c] = 20'h80000;
                            pipe_next[k].sat    = 1'b1;
                        end
                        else
                        begin
                            pipe_next[k].pos[c] = p[19:0];
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    pipe_reg[k] <= pipe_next[k];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (en[k])
                begin
                    valid_reg[k] <= (k == 0) ? samples.valid : valid_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    assign samples.ready       = en[0];
    assign positions.valid     = valid_reg[SAT_ST];
    assign positions.pos_x     = pipe_reg[SAT_ST].pos[0];
    assign positions.pos_y     = pipe_reg[SAT_ST].pos[1];
    assign positions.pos_z     = pipe_reg[SAT_ST].pos[2];
    assign positions.saturated = pipe_reg[SAT_ST].sat;

    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> valid_reg[0])
        else $error("accepted beat did not enter the first stage");

    a_box_no_scale: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] && shape_reg != SHAPE_CYL && shape_reg != SHAPE_ELL
        |-> pipe_reg[2].scl == 3'b000)
        else $error("scaling flagged in box mode");

    a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[DV_FIRST-1]
        |-> (34'(pipe_reg[DV_FIRST-1].root) * 34'(pipe_reg[DV_FIRST-1].root)
                 <= 34'(pipe_reg[DV_FIRST-1].s))
         && ((34'(pipe_reg[DV_FIRST-1].root) + 34'd1)
                 * (34'(pipe_reg[DV_FIRST-1].root) + 34'd1)
                 > 34'(pipe_reg[DV_FIRST-1].s)))
        else $error("square root stage result is not the floor root");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        positions.valid && positions.saturated
        |-> positions.pos_x == 20'sh7FFFF || positions.pos_x == -20'sh80000
         || positions.pos_y == 20'sh7FFFF || positions.pos_y == -20'sh80000
         || positions.pos_z == 20'sh7FFFF || positions.pos_z == -20'sh80000)
        else $error("saturated flag without a clamped coordinate");

endmodule
`default_nettype wire
